/* rtl/piecewise_linear_calibration_top_defines.svh */
// Assertion macros shared by the calibration table checker
`ifndef PIECEWISE_LINEAR_CALIBRATION_TOP_DEFINES_SVH
`define PIECEWISE_LINEAR_CALIBRATION_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define PLC_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("calibration table check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define PLC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("calibration table check failed");

`endif

/* rtl/plc_pkg.sv */
// Types and constants of the piecewise-linear calibration table
`default_nettype none

package plc_pkg;

    localparam int DATA_W    = 32;
    localparam int PROD_W    = 64;
    localparam int CNT_W     = 5;
    localparam int IDX_W     = 4;
    localparam int DIV_STEPS = 64;
    localparam int STEP_W    = 6;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_MUL,
        ST_DIVGO,
        ST_DIV,
        ST_OUT
    } plc_state_t;

endpackage

`default_nettype wire

/* rtl/plc_ram.sv */
// Generic single-port-write, registered-read memory
`default_nettype none

module plc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/plc_div.sv */
// Bit-serial signed divider, 64-bit dividend by 32-bit divisor, low 32 quotient bits
`default_nettype none

module plc_div
    import plc_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic signed [PROD_W-1:0] dividend,
    input  wire logic signed [DATA_W-1:0] divisor,
    output logic                          done,
    output logic        [DATA_W-1:0]      quotient
);

    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [PROD_W-1:0] dvd_reg, dvd_next;
    logic [DATA_W-1:0] dvs_reg, dvs_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic              neg_reg, neg_next;

    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;

    assign shifted = {rem_reg, dvd_reg[PROD_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            // divide magnitudes, fix the sign at the end
            dvd_next = dividend[PROD_W-1] ? (PROD_W'(0) - dividend) : dividend;
            dvs_next = divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
            neg_next = dividend[PROD_W-1] ^ divisor[DATA_W-1];
            rem_next = '0;
            quo_next = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (!diff[DATA_W])
            begin
                rem_next = diff[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            dvd_next = {dvd_reg[PROD_W-2:0], 1'b0};
            cnt_next = cnt_reg + STEP_W'(1);
            if (cnt_reg == STEP_W'(DIV_STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (DATA_W'(0) - quo_reg) : quo_reg;

endmodule

`default_nettype wire

/* rtl/piecewise_linear_calibration_top.sv */
// Piecewise-linear calibration table: point store, scan sequencer, interpolation
// Write item: taken on accept, busy stays low, no result.
// Query item: each scanned entry is read, then compared, over the entries in use
//   (count_reg capped at MAX_POINTS); interpolation then multiplies, loads the divider,
//   divides. Done marks the end. One item at a time; the next start waits for idle.
// Reset clears count_reg to 0 and idles the sequencer; table entries are not cleared.
`default_nettype none

module piecewise_linear_calibration_top
    import plc_pkg::*;
#(
    parameter int MAX_POINTS = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic                     operation,
    input  wire logic [IDX_W-1:0]         point_index,
    input  wire logic signed [DATA_W-1:0] point_x,
    input  wire logic signed [DATA_W-1:0] point_y,
    input  wire logic signed [DATA_W-1:0] query_x,
    output logic                          done,
    output logic signed [DATA_W-1:0]      calibrated_value,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CNT_W-1:0]         cfg_data
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int UW = $clog2(MAX_POINTS + 1);
    localparam int EW = (UW > CNT_W) ? UW : CNT_W;

    plc_state_t state_reg, state_next;

    logic [CNT_W-1:0]         count_reg;
    logic [UW-1:0]            used_reg, used_next;
    logic [UW-1:0]            idx_reg, idx_next;
    logic                     have_prev_reg, have_prev_next;

    logic signed [DATA_W-1:0] query_reg, query_next;
    logic signed [DATA_W-1:0] px_reg, px_next;
    logic signed [DATA_W-1:0] py_reg, py_next;
    logic signed [DATA_W-1:0] dx_reg, dx_next;
    logic signed [DATA_W-1:0] dy_reg, dy_next;
    logic signed [DATA_W-1:0] dd_reg, dd_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [DATA_W-1:0] result_reg, result_next;

    logic                     accept;
    logic [EW-1:0]            count_ext;
    logic [EW-1:0]            used_w;
    logic [EW-1:0]            windex_ext;
    logic                     ram_we;
    logic                     ram_re;
    logic [2*DATA_W-1:0]      ram_rdata;
    logic signed [DATA_W-1:0] rd_x;
    logic signed [DATA_W-1:0] rd_y;
    logic                     hit;
    logic                     above;
    logic                     last;
    logic                     div_start;
    logic                     div_done;
    logic [DATA_W-1:0]        div_quot;

    assign accept     = start && (state_reg == ST_IDLE);
    assign count_ext  = EW'(count_reg);
    assign used_w     = (count_ext > EW'(MAX_POINTS)) ? EW'(MAX_POINTS) : count_ext;
    assign windex_ext = EW'(point_index);
    assign ram_we     = accept && (operation == OP_WRITE) && (windex_ext < EW'(MAX_POINTS));

    assign rd_x  = ram_rdata[2*DATA_W-1:DATA_W];
    assign rd_y  = ram_rdata[DATA_W-1:0];
    assign hit   = (rd_x == query_reg);
    assign above = (rd_x > query_reg);
    assign last  = ((idx_reg + UW'(1)) == used_reg);

    // x in the upper half, y in the lower; writes only happen while idle
    plc_ram #(
        .WIDTH (2 * DATA_W),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (windex_ext[AW-1:0]),
        .wdata ({point_x, point_y}),
        .re    (ram_re),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    plc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (dd_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (operation == OP_QUERY))
                begin
                    state_next = (used_w == '0) ? ST_OUT : ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (hit)
                begin
                    state_next = ST_OUT;
                end
                else if (above)
                begin
                    state_next = (have_prev_reg && (rd_x != px_reg)) ? ST_MUL : ST_OUT;
                end
                else
                begin
                    state_next = last ? ST_OUT : ST_READ;
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIVGO;
            end
            ST_DIVGO:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        ram_re    = 1'b0;
        div_start = 1'b0;
        done      = 1'b0;
        busy      = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_READ:
            begin
                ram_re = 1'b1;
            end
            ST_DIVGO:
            begin
                div_start = 1'b1;
            end
            ST_OUT:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        used_next      = used_reg;
        idx_next       = idx_reg;
        have_prev_next = have_prev_reg;
        query_next     = query_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        dd_next        = dd_reg;
        prod_next      = prod_reg;
        result_next    = result_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (operation == OP_QUERY))
                begin
                    query_next     = query_x;
                    used_next      = used_w[UW-1:0];
                    idx_next       = '0;
                    have_prev_next = 1'b0;
                    result_next    = '0;
                end
            end
            ST_CHECK:
            begin
                if (hit)
                begin
                    result_next = rd_y;
                end
                else if (above)
                begin
                    if (!have_prev_reg)
                    begin
                        result_next = '0;
                    end
                    else if (rd_x == px_reg)
                    begin
                        result_next = py_reg;
                    end
                    else
                    begin
                        dx_next = query_reg - px_reg;
                        dy_next = rd_y - py_reg;
                        dd_next = rd_x - px_reg;
                    end
                end
                else
                begin
                    // point lies below the query: it becomes the lower neighbor
                    px_next        = rd_x;
                    py_next        = rd_y;
                    have_prev_next = 1'b1;
                    idx_next       = idx_reg + UW'(1);
                    result_next    = '0;
                end
            end
            ST_MUL:
            begin
                prod_next = dx_reg * dy_reg;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    result_next = py_reg + div_quot;
                end
            end
            default:
            begin
                result_next = result_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            used_reg      <= '0;
            idx_reg       <= '0;
            have_prev_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            idx_reg       <= idx_next;
            have_prev_reg <= have_prev_next;
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        query_reg  <= query_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        dd_reg     <= dd_next;
        prod_reg   <= prod_next;
        result_reg <= result_next;
    end

    assign cfg_ready        = (state_reg == ST_IDLE);
    assign calibrated_value = result_reg;

endmodule

`default_nettype wire

/* rtl/plc_checker.sv */
// Port-level checks of the calibration table, bound to the top level
`default_nettype none

`include "piecewise_linear_calibration_top_defines.svh"

module plc_checker
    import plc_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic operation,
    input wire logic done
);

    `PLC_ASSERT_NOW(a_done_while_busy, done, busy)
    `PLC_ASSERT_NEXT(a_done_one_cycle, done, !done && !busy)
    `PLC_ASSERT_NEXT(a_write_no_result, start && !busy && (operation == OP_WRITE), !busy && !done)
    `PLC_ASSERT_NEXT(a_query_goes_busy, start && !busy && (operation == OP_QUERY), busy)

endmodule

bind piecewise_linear_calibration_top plc_checker u_plc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .operation (operation),
    .done      (done)
);

`default_nettype wire
